// File: sv/tsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_pkg: shared types, codes and ordering functions
// Payload structs, register and mode codes, the sorter cell record and the
// functions that turn raw element bits into an unsigned ordering key.
// ----------------------------------------------------------------------------
package tsd_pkg;

	// Default store depth
	localparam int MAX_ELEMENTS_DEF = 64;

	// Configuration port geometry
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 4;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_TYPE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORDER_MODE   = 2'd1;

	// Element type codes
	localparam logic [3:0] TYPE_S8  = 4'd0;
	localparam logic [3:0] TYPE_U8  = 4'd1;
	localparam logic [3:0] TYPE_S16 = 4'd2;
	localparam logic [3:0] TYPE_U16 = 4'd3;
	localparam logic [3:0] TYPE_S32 = 4'd4;
	localparam logic [3:0] TYPE_U32 = 4'd5;
	localparam logic [3:0] TYPE_F32 = 4'd6;
	localparam logic [3:0] TYPE_S64 = 4'd7;
	localparam logic [3:0] TYPE_U64 = 4'd8;
	localparam logic [3:0] TYPE_F64 = 4'd9;

	// Order mode codes
	localparam logic [1:0] MODE_ASC  = 2'd0;
	localparam logic [1:0] MODE_DESC = 2'd1;
	localparam logic [1:0] MODE_UNIQ = 2'd2;

	// Register reset values
	localparam logic [3:0] ELEMENT_TYPE_RST = TYPE_S32;
	localparam logic [1:0] ORDER_MODE_RST   = MODE_ASC;

	typedef struct packed {
		logic [63:0] element_bits;
		logic        final_element;
	} tsd_in_t;

	typedef struct packed {
		logic [63:0] sorted_bits;
		logic        final_result;
		logic [6:0]  result_count;
		logic        dropped_flag;
	} tsd_out_t;

	// One sorter cell: occupancy, ordering key and raw bits
	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [63:0] bits;
	} tsd_cell_t;

	// Chain control
	typedef struct packed {
		logic insert;
		logic shift_out;
		logic descend;
	} tsd_ctrl_t;

	typedef enum logic [1:0] {
		PH_LOAD,
		PH_SORT,
		PH_EMIT
	} tsd_phase_t;

	// Mask of the element width; unused codes act as 64 bits
	function automatic logic [63:0] width_mask(input logic [3:0] etype);
		logic [63:0] m;
		case (etype)
			TYPE_S8, TYPE_U8:            m = 64'h0000_0000_0000_00FF;
			TYPE_S16, TYPE_U16:          m = 64'h0000_0000_0000_FFFF;
			TYPE_S32, TYPE_U32, TYPE_F32: m = 64'h0000_0000_FFFF_FFFF;
			default:                     m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	// Top bit of the element width
	function automatic logic [63:0] sign_bit(input logic [3:0] etype);
		logic [63:0] s;
		case (etype)
			TYPE_S8, TYPE_U8:            s = 64'h0000_0000_0000_0080;
			TYPE_S16, TYPE_U16:          s = 64'h0000_0000_0000_8000;
			TYPE_S32, TYPE_U32, TYPE_F32: s = 64'h0000_0000_8000_0000;
			default:                     s = 64'h8000_0000_0000_0000;
		endcase
		return s;
	endfunction

	// Unsigned key that orders like the typed value
	function automatic logic [63:0] order_key(input logic [63:0] raw,
			input logic [3:0] etype);
		logic [63:0] m;
		logic [63:0] s;
		logic [63:0] b;
		logic [63:0] k;
		m = width_mask(etype);
		s = sign_bit(etype);
		b = raw & m;
		case (etype)
			TYPE_S8, TYPE_S16, TYPE_S32, TYPE_S64: k = b ^ s;
			TYPE_F32, TYPE_F64: begin
				// both zeros map to the same key
				if ((b & ~s) == 64'd0)
					k = s;
				else if ((b & s) != 64'd0)
					k = ~b & m;
				else
					k = b | s;
			end
			default: k = b;
		endcase
		return k;
	endfunction

endpackage

// File: sv/tsd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_cell: one insertion sort cell
// Holds one element. On insert it keeps its element, takes the broadcast
// entry or takes its left neighbor's element; on shift it takes the right one.
// ----------------------------------------------------------------------------
module tsd_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  tsd_pkg::tsd_ctrl_t  ctrl,
	input  tsd_pkg::tsd_cell_t  entry,
	input  tsd_pkg::tsd_cell_t  left,
	input  logic                left_ins,
	input  tsd_pkg::tsd_cell_t  right,
	output tsd_pkg::tsd_cell_t  held,
	output logic                ins,
	output logic                eq
);

	tsd_pkg::tsd_cell_t held_q;
	tsd_pkg::tsd_cell_t held_d;
	logic               valid_q;
	logic [63:0]        key_q;
	logic [63:0]        bits_q;
	logic               ahead;

	// Entry strictly ahead of the held element; ties keep arrival order
	assign ahead = ctrl.descend ? (entry.key > held_q.key) : (entry.key < held_q.key);
	assign ins   = !held_q.valid || ahead;
	assign eq    = held_q.valid && (entry.key == held_q.key);

	// Next content
	always_comb begin
		held_d = held_q;
		if (ctrl.insert) begin
			if (ins)
				held_d = left_ins ? left : entry;
		end else if (ctrl.shift_out) begin
			held_d = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= held_d.valid;
	end

	always_ff @(posedge clk) begin
		key_q  <= held_d.key;
		bits_q <= held_d.bits;
	end

	assign held_q = '{valid: valid_q, key: key_q, bits: bits_q};
	assign held   = held_q;

endmodule

// File: sv/tsd_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_chain: row of insertion sort cells
// Cell 0 is the head. Inserts land at their sorted place;
// shifting moves every element one cell toward the head.
// ----------------------------------------------------------------------------
module tsd_chain #(
	parameter int MAX_ELEMENTS = tsd_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tsd_pkg::tsd_ctrl_t  ctrl,
	input  tsd_pkg::tsd_cell_t  entry,
	output tsd_pkg::tsd_cell_t  head,
	output tsd_pkg::tsd_cell_t  next,
	output logic                any_eq
);

	tsd_pkg::tsd_cell_t         held [MAX_ELEMENTS];
	tsd_pkg::tsd_cell_t         left_c [MAX_ELEMENTS];
	tsd_pkg::tsd_cell_t         right_c [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0]    ins;
	logic [MAX_ELEMENTS-1:0]    left_ins;
	logic [MAX_ELEMENTS-1:0]    eq;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		// Neighbor wiring; the ends see empty cells
		if (i == 0) begin : g_first
			assign left_c[i]   = '0;
			assign left_ins[i] = 1'b0;
		end else begin : g_mid_l
			assign left_c[i]   = held[i-1];
			assign left_ins[i] = ins[i-1];
		end
		if (i == MAX_ELEMENTS - 1) begin : g_last
			assign right_c[i] = '0;
		end else begin : g_mid_r
			assign right_c[i] = held[i+1];
		end

		tsd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.entry    (entry),
			.left     (left_c[i]),
			.left_ins (left_ins[i]),
			.right    (right_c[i]),
			.held     (held[i]),
			.ins      (ins[i]),
			.eq       (eq[i])
		);
	end

	assign head   = held[0];
	assign next   = held[1];
	assign any_eq = |eq;

endmodule

// File: sv/typed_sort_and_dedupe_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_sort_and_dedupe_core: typed sort with optional duplicate removal
// Collects element words into a store, then sorts them through a row of
// insertion cells and streams them out.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel (valid/ready): one element per transfer, one per cycle while
//    loading. final_element closes the set; ready drops until it is emitted.
//  - Elements beyond MAX_ELEMENTS are dropped and flagged in every result.
//  - After the final transfer the store is read once, one element per cycle,
//    into the cell row. Results then leave one per cycle from the head cell
//    while ready allows; each dropped duplicate takes a shift with no result.
//  - The single store read port sets the sort time.
//  - result channel (valid/ready): a stall on ready holds the output register
//    and pauses the cell row but for dropped duplicates; nothing is lost.
//  - cfg port: writes take effect at once; write only between sets.
//  - Reset clears the fill count, flags, cell valid bits and registers
//    (type s32, ascending). The store itself is not cleared.
// ----------------------------------------------------------------------------
module typed_sort_and_dedupe_core #(
	parameter int MAX_ELEMENTS = tsd_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  tsd_pkg::tsd_in_t                    item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output tsd_pkg::tsd_out_t                   result,
	input  logic                                cfg_we,
	input  logic [tsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tsd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	// Configuration registers
	logic [3:0]           etype_q;
	logic [1:0]           mode_q;

	// Control state
	tsd_pkg::tsd_phase_t  phase_q;
	tsd_pkg::tsd_phase_t  phase_d;
	logic [CW-1:0]        fill_q;
	logic                 overflow_q;
	logic [CW-1:0]        rd_idx_q;
	logic [CW-1:0]        dup_q;
	logic [CW-1:0]        rem_q;
	logic                 rd_valid_s1;
	logic [63:0]          rd_data_s1;
	logic                 result_valid_q;
	tsd_pkg::tsd_out_t    result_q;

	logic [63:0]          store_mem [MAX_ELEMENTS];

	logic                 item_xfer;
	logic                 store_full;
	logic                 issue_rd;
	logic                 uniq;
	logic                 skip;
	logic                 slot_free;
	logic                 pop;
	logic                 load_out;
	logic                 sort_done;
	logic                 emit_done;
	logic [CW-1:0]        total;
	logic [63:0]          cur_mask;
	logic [63:0]          entry_bits;
	tsd_pkg::tsd_ctrl_t   ctrl;
	tsd_pkg::tsd_cell_t   entry;
	tsd_pkg::tsd_cell_t   head;
	tsd_pkg::tsd_cell_t   next;
	logic                 any_eq;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			etype_q <= tsd_pkg::ELEMENT_TYPE_RST;
			mode_q  <= tsd_pkg::ORDER_MODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tsd_pkg::REG_ELEMENT_TYPE: etype_q <= cfg_data;
				tsd_pkg::REG_ORDER_MODE:   mode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cur_mask   = tsd_pkg::width_mask(etype_q);
	assign uniq       = (mode_q == tsd_pkg::MODE_UNIQ);
	assign item_xfer  = item_valid && item_ready;
	assign store_full = (fill_q >= CW'(MAX_ELEMENTS));
	assign sort_done  = (rd_idx_q == fill_q) && !rd_valid_s1;
	assign emit_done  = (rem_q == '0);

	// Phase: next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			tsd_pkg::PH_LOAD: if (item_xfer && item.final_element) phase_d = tsd_pkg::PH_SORT;
			tsd_pkg::PH_SORT: if (sort_done) phase_d = tsd_pkg::PH_EMIT;
			tsd_pkg::PH_EMIT: if (emit_done) phase_d = tsd_pkg::PH_LOAD;
			default:          phase_d = tsd_pkg::PH_LOAD;
		endcase
	end

	// Phase: outputs
	always_comb begin
		item_ready = 1'b0;
		issue_rd   = 1'b0;
		pop        = 1'b0;
		case (phase_q)
			tsd_pkg::PH_LOAD: item_ready = 1'b1;
			tsd_pkg::PH_SORT: issue_rd   = (rd_idx_q < fill_q);
			tsd_pkg::PH_EMIT: pop        = !emit_done && (skip || slot_free);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= tsd_pkg::PH_LOAD;
		else
			phase_q <= phase_d;
	end

	// Fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			overflow_q <= 1'b0;
		end else if (item_xfer) begin
			if (store_full)
				overflow_q <= 1'b1;
			else
				fill_q <= fill_q + 1'b1;
		end else if (phase_q == tsd_pkg::PH_EMIT && emit_done) begin
			fill_q     <= '0;
			overflow_q <= 1'b0;
		end
	end

	// Element store: masked on write, registered read
	always_ff @(posedge clk) begin
		if (item_xfer && !store_full)
			store_mem[fill_q[AW-1:0]] <= item.element_bits & cur_mask;
		rd_data_s1 <= store_mem[rd_idx_q[AW-1:0]];
	end

	// Read sequencing and duplicate pair count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			rd_valid_s1 <= 1'b0;
			dup_q       <= '0;
			rem_q       <= '0;
		end else begin
			rd_valid_s1 <= issue_rd;
			if (issue_rd)
				rd_idx_q <= rd_idx_q + 1'b1;
			// an insert that meets an equal key adds one adjacent pair
			if (rd_valid_s1 && any_eq)
				dup_q <= dup_q + 1'b1;
			if (phase_q == tsd_pkg::PH_SORT && sort_done)
				rem_q <= fill_q;
			else if (pop)
				rem_q <= rem_q - 1'b1;
			if (phase_q == tsd_pkg::PH_EMIT && emit_done) begin
				rd_idx_q <= '0;
				dup_q    <= '0;
			end
		end
	end

	// Broadcast entry, masked and keyed with the current type
	assign entry_bits = rd_data_s1 & cur_mask;
	assign entry.valid = 1'b1;
	assign entry.bits  = entry_bits;
	assign entry.key   = tsd_pkg::order_key(entry_bits, etype_q);

	assign ctrl.insert    = rd_valid_s1;
	assign ctrl.shift_out = pop;
	assign ctrl.descend   = (mode_q == tsd_pkg::MODE_DESC);

	tsd_chain #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.entry  (entry),
		.head   (head),
		.next   (next),
		.any_eq (any_eq)
	);

	// Emit: keep only the last of each equal run in unique mode
	assign skip      = uniq && next.valid && (head.key == next.key);
	assign slot_free = !result_valid_q || result_ready;
	assign load_out  = pop && !skip;
	assign total     = uniq ? (fill_q - dup_q) : fill_q;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (load_out)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.sorted_bits  <= head.bits;
			result_q.final_result <= (rem_q == CW'(1));
			result_q.result_count <= 7'(total);
			result_q.dropped_flag <= overflow_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	// Fill count never passes the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(MAX_ELEMENTS))
		else $error("fill count beyond store depth");

	// Inserts only happen while sorting
	a_insert_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> phase_q == tsd_pkg::PH_SORT)
		else $error("cell insert outside sort phase");

	// Head cell occupancy tracks the remaining count while emitting
	a_head_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tsd_pkg::PH_EMIT |-> head.valid == (rem_q != '0))
		else $error("head cell out of step with remaining count");

	// Remaining count never exceeds what was loaded
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tsd_pkg::PH_EMIT |-> rem_q <= fill_q)
		else $error("remaining count beyond fill count");
`endif

endmodule

// File: test/typed_sort_and_dedupe_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_sort_and_dedupe_core_test: self-checking bench for the typed sorter
// Streams element sets into the core under every element type and order mode.
// A scoreboard keeps its own copy of the store and sorts each set on the
// final transfer. Every result transfer is checked against that prediction
// while both channels idle and stall in several patterns.
// ----------------------------------------------------------------------------
module typed_sort_and_dedupe_core_test;

	localparam int DEPTH        = tsd_pkg::MAX_ELEMENTS_DEF;
	localparam int SETTLE       = DEPTH + 16;
	localparam int LIMIT        = 300000;
	localparam int RANDOM_ITEMS = 240;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;

	// Codes outside the defined ranges
	localparam logic [3:0]                      TYPE_SPARE  = 4'd13;
	localparam logic [3:0]                      MODE_SPARE  = 4'd3;
	localparam logic [tsd_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [tsd_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	localparam logic [63:0] F32_EXP = 64'h0000_0000_7F80_0000;
	localparam logic [63:0] F64_EXP = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] F64_ONE = 64'h3FF0_0000_0000_0000;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            item_valid   = 1'b0;
	logic                            item_ready;
	tsd_pkg::tsd_in_t                item         = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	tsd_pkg::tsd_out_t               result;
	logic                            cfg_we       = 1'b0;
	logic [tsd_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [tsd_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

	// Scoreboard state
	logic [63:0]       held [DEPTH];
	int                held_count    = 0;
	logic              held_overflow = 1'b0;
	logic [3:0]        active_type   = tsd_pkg::ELEMENT_TYPE_RST;
	logic [1:0]        active_mode   = tsd_pkg::ORDER_MODE_RST;
	tsd_pkg::tsd_out_t due_results [$];

	// Traffic shaping
	int          sender_idle_pct = 0;
	int          stall_pct       = 0;
	logic        hold_on         = 1'b0;
	logic [63:0] pool [4];

	int          fault_count = 0;
	int          cycle_count = 0;

	typed_sort_and_dedupe_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				due_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Element width as a mask; spare type codes are 64 bits wide
	function automatic logic [63:0] elem_mask(input logic [3:0] etype);
		int w;
		case (etype)
			tsd_pkg::TYPE_S8, tsd_pkg::TYPE_U8:                    w = 8;
			tsd_pkg::TYPE_S16, tsd_pkg::TYPE_U16:                  w = 16;
			tsd_pkg::TYPE_S32, tsd_pkg::TYPE_U32, tsd_pkg::TYPE_F32: w = 32;
			default:                                               w = 64;
		endcase
		return (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	// Unsigned key with the same order as the typed value
	function automatic logic [63:0] sort_key(input logic [63:0] raw, input logic [3:0] etype);
		logic [63:0] keep;
		logic [63:0] top;
		logic [63:0] v;
		keep = elem_mask(etype);
		top  = keep ^ (keep >> 1);
		v    = raw & keep;
		case (etype)
			tsd_pkg::TYPE_S8, tsd_pkg::TYPE_S16, tsd_pkg::TYPE_S32, tsd_pkg::TYPE_S64:
				return v ^ top;
			tsd_pkg::TYPE_F32, tsd_pkg::TYPE_F64: begin
				// +0 and -0 share one key; negatives invert
				if ((v & ~top) == '0)
					return top;
				if ((v & top) != '0)
					return ~v & keep;
				return v | top;
			end
			default: return v;
		endcase
	endfunction

	function automatic logic comes_first(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ka;
		logic [63:0] kb;
		ka = sort_key(a, active_type);
		kb = sort_key(b, active_type);
		return (active_mode == tsd_pkg::MODE_DESC) ? (ka > kb) : (ka < kb);
	endfunction

	// Store one accepted element; on the final one, sort the set and queue its results
	function automatic void absorb_element(input logic [63:0] bits, input logic is_last);
		logic [63:0]       keep;
		logic [63:0]       ord [DEPTH];
		logic [63:0]       v;
		int                n;
		int                i;
		int                j;
		int                kept;
		tsd_pkg::tsd_out_t r;
		keep = elem_mask(active_type);
		if (held_count < DEPTH) begin
			held[held_count] = bits & keep;
			held_count++;
		end else begin
			held_overflow = 1'b1;
		end
		if (!is_last)
			return;
		n = held_count;
		// stable insertion sort
		for (i = 0; i < n; i++) begin
			v = held[i];
			j = i;
			while (j > 0 && comes_first(v, ord[j-1])) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = v;
		end
		// keep the last of each run of equal keys
		kept = n;
		if (active_mode == tsd_pkg::MODE_UNIQ) begin
			kept = 0;
			for (i = 0; i + 1 < n; i++) begin
				if (sort_key(ord[i], active_type) != sort_key(ord[i+1], active_type)) begin
					ord[kept] = ord[i];
					kept++;
				end
			end
			ord[kept] = ord[n-1];
			kept++;
		end
		for (i = 0; i < kept; i++) begin
			r.sorted_bits  = ord[i];
			r.final_result = (i == kept - 1);
			r.result_count = 7'(kept);
			r.dropped_flag = held_overflow;
			due_results.push_back(r);
		end
		held_count    = 0;
		held_overflow = 1'b0;
	endfunction

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Boundary values: zeros, limits, infinities, NaNs, smallest magnitude
	function automatic logic [63:0] special_value(input logic [3:0] etype);
		logic [63:0] keep;
		logic [63:0] top;
		logic [63:0] expo;
		keep = elem_mask(etype);
		top  = keep ^ (keep >> 1);
		expo = (etype == tsd_pkg::TYPE_F32) ? F32_EXP :
			(etype == tsd_pkg::TYPE_F64) ? F64_EXP : (keep >> 1);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return top;
			2:       return expo;
			3:       return expo | top;
			4:       return expo | 64'd1;
			5:       return expo | top | 64'd1;
			6:       return 64'd1;
			default: return keep;
		endcase
	endfunction

	function automatic void refill_pool();
		for (int i = 0; i < 4; i++)
			pool[i] = ($urandom_range(0, 1) != 0) ? special_value(active_type) : random_word();
	endfunction

	// Mix of repeats from the pool, boundary values and noise; junk above the width
	function automatic logic [63:0] pick_element();
		logic [63:0] keep;
		logic [63:0] base;
		int          r;
		keep = elem_mask(active_type);
		r    = $urandom_range(0, 99);
		if (r < 35)
			base = pool[$urandom_range(0, 3)];
		else if (r < 55)
			base = special_value(active_type);
		else
			base = random_word();
		if ($urandom_range(0, 1) != 0)
			base = (base & keep) | (random_word() & ~keep);
		return base;
	endfunction

	task automatic report_fault(input string what, input tsd_pkg::tsd_out_t want,
			input tsd_pkg::tsd_out_t got);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("%0t %s: expected %h/%b/%0d/%b, got %h/%b/%0d/%b",
				$time, what, want.sorted_bits, want.final_result, want.result_count,
				want.dropped_flag, got.sorted_bits, got.final_result, got.result_count,
				got.dropped_flag);
	endtask

	// Result side: check each transfer, then pick the next ready
	always @(posedge clk) begin
		tsd_pkg::tsd_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (due_results.size() == 0) begin
				report_fault("unexpected result", '0, result);
			end else begin
				want = due_results.pop_front();
				if (result.sorted_bits !== want.sorted_bits ||
						result.final_result !== want.final_result ||
						result.result_count !== want.result_count ||
						result.dropped_flag !== want.dropped_flag)
					report_fault("result mismatch", want, result);
			end
		end
		result_ready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
	end

	// Offer one element and hold it until the transfer
	task automatic send_element(input logic [63:0] bits, input logic is_last);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{element_bits: bits, final_element: is_last};
		do begin
			@(posedge clk);
		end while (!item_ready);
		absorb_element(bits, is_last);
	endtask

	// Wait for all queued results plus the tail of the emit pass
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tsd_pkg::CFG_INDEX_W-1:0] idx,
			input logic [tsd_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == tsd_pkg::REG_ELEMENT_TYPE)
			active_type = data[3:0];
		else if (idx == tsd_pkg::REG_ORDER_MODE)
			active_mode = data[1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// 0 none, 1 sender gaps, 2 receiver stalls, 3 both
	task automatic set_profile(input int p);
		case (p)
			1:       begin sender_idle_pct = 80; stall_pct <= 0;  end
			2:       begin sender_idle_pct = 0;  stall_pct <= 80; end
			3:       begin sender_idle_pct = 28; stall_pct <= 28; end
			default: begin sender_idle_pct = 0;  stall_pct <= 0;  end
		endcase
	endtask

	task automatic send_set(input int size);
		refill_pool();
		for (int k = 0; k < size; k++)
			send_element(pick_element(), k == size - 1);
	endtask

	// Hand-picked sets: register reset values, limits, zeros, NaNs, spare codes
	task automatic test_directed();
		set_profile(0);
		// reset setting is s32 ascending; junk above bit 31
		send_element(64'hDEAD_BEEF_7FFF_FFFF, 1'b0);
		send_element(64'h0000_0001_8000_0000, 1'b0);
		send_element(64'hFFFF_FFFF_0000_0000, 1'b0);
		send_element(64'h1234_5678_FFFF_FFFF, 1'b1);
		send_element('1, 1'b1);
		wait_idle();
		// doubles, duplicates removed: zeros, infinities, NaNs of both signs
		write_reg(tsd_pkg::REG_ELEMENT_TYPE, tsd_pkg::TYPE_F64);
		write_reg(tsd_pkg::REG_ORDER_MODE, tsd_pkg::CFG_DATA_W'(tsd_pkg::MODE_UNIQ));
		send_element(64'd0, 1'b0);
		send_element(64'h8000_0000_0000_0000, 1'b0);
		send_element(F64_EXP, 1'b0);
		send_element(F64_EXP | 64'h8000_0000_0000_0000, 1'b0);
		send_element(F64_EXP | 64'd1, 1'b0);
		send_element(F64_EXP | 64'h8000_0000_0000_0001, 1'b0);
		send_element(F64_ONE, 1'b0);
		send_element(F64_ONE, 1'b1);
		wait_idle();
		// bytes, descending
		write_reg(tsd_pkg::REG_ELEMENT_TYPE, tsd_pkg::TYPE_S8);
		write_reg(tsd_pkg::REG_ORDER_MODE, tsd_pkg::CFG_DATA_W'(tsd_pkg::MODE_DESC));
		send_element(64'hFFFF_FFFF_FFFF_FF80, 1'b0);
		send_element(64'h0000_0000_0000_007F, 1'b0);
		send_element(64'h0000_0000_0000_00FF, 1'b0);
		send_element(64'h0000_0000_0000_AB00, 1'b1);
		wait_idle();
		// spare type and mode codes; writes to unmapped indexes change nothing
		write_reg(tsd_pkg::REG_ELEMENT_TYPE, TYPE_SPARE);
		write_reg(tsd_pkg::REG_ORDER_MODE, MODE_SPARE);
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, tsd_pkg::CFG_DATA_W'(tsd_pkg::MODE_DESC));
		send_element('1, 1'b0);
		send_element(64'd0, 1'b0);
		send_element(64'h8000_0000_0000_0000, 1'b1);
		wait_idle();
		// single floats: -0 and +0 keep arrival order; mode data masked to 2 bits
		write_reg(tsd_pkg::REG_ELEMENT_TYPE, tsd_pkg::TYPE_F32);
		write_reg(tsd_pkg::REG_ORDER_MODE, {2'b11, tsd_pkg::MODE_ASC});
		send_element(64'h0000_0000_8000_0000, 1'b0);
		send_element(64'd0, 1'b0);
		send_element(64'hFFFF_FFFF_8000_0000, 1'b1);
		wait_idle();
	endtask

	// Full store, then overflow where the final element itself is dropped
	task automatic test_store_limits();
		set_profile(3);
		write_reg(tsd_pkg::REG_ELEMENT_TYPE, tsd_pkg::TYPE_U8);
		write_reg(tsd_pkg::REG_ORDER_MODE, tsd_pkg::CFG_DATA_W'(tsd_pkg::MODE_UNIQ));
		send_set(DEPTH);
		wait_idle();
		write_reg(tsd_pkg::REG_ELEMENT_TYPE, tsd_pkg::TYPE_S64);
		write_reg(tsd_pkg::REG_ORDER_MODE, tsd_pkg::CFG_DATA_W'(tsd_pkg::MODE_DESC));
		send_set(DEPTH + 3);
		wait_idle();
	endtask

	// Receiver holds off for a long stretch while sets keep coming
	task automatic test_backpressure();
		set_profile(0);
		write_reg(tsd_pkg::REG_ELEMENT_TYPE, tsd_pkg::TYPE_U32);
		write_reg(tsd_pkg::REG_ORDER_MODE, tsd_pkg::CFG_DATA_W'(tsd_pkg::MODE_ASC));
		fork
			begin
				hold_on <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		send_set(12);
		send_set(6);
		send_set(3);
		wait_idle();
	endtask

	// Random sets under changing settings and traffic profiles
	task automatic test_random();
		int sent;
		int set_no;
		int size;
		int r;
		sent   = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			set_profile((set_no / 3) % 4);
			if ($urandom_range(0, 99) < 40) begin
				wait_idle();
				write_reg(tsd_pkg::REG_ELEMENT_TYPE, ($urandom_range(0, 99) < 85) ?
					tsd_pkg::CFG_DATA_W'($urandom_range(tsd_pkg::TYPE_S8, tsd_pkg::TYPE_F64)) :
					tsd_pkg::CFG_DATA_W'($urandom_range(10, 15)));
				write_reg(tsd_pkg::REG_ORDER_MODE, tsd_pkg::CFG_DATA_W'($urandom_range(0, 15)));
				if ($urandom_range(0, 99) < 15)
					write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
						tsd_pkg::CFG_DATA_W'($urandom_range(0, 15)));
			end
			// mostly short sets, some long, a few full or overflowing
			r = $urandom_range(0, 99);
			if (r < 70)
				size = $urandom_range(1, 8);
			else if (r < 90)
				size = $urandom_range(9, 30);
			else if (r < 97)
				size = $urandom_range(DEPTH - 4, DEPTH);
			else
				size = $urandom_range(DEPTH + 1, DEPTH + 6);
			send_set(size);
			sent += size;
			set_no++;
		end
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_store_limits();
		test_backpressure();
		test_random();
		if (fault_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
